// File: hdl/rdyq_pkg.sv
// Package: types, field widths and operation codes for the ready queue.
package rdyq_pkg;

    localparam int ID_BITS   = 8;
    localparam int PRIO_BITS = 8;
    localparam int DEPTH_DEF = 16;

    // Operation codes carried in the func field
    localparam logic [1:0] FUNC_ENQUEUE = 2'd0;
    localparam logic [1:0] FUNC_DEQUEUE = 2'd1;
    localparam logic [1:0] FUNC_PEEK    = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]           func;
        logic [ID_BITS-1:0]   task_id;
        logic [PRIO_BITS-1:0] task_priority;
    } rdyq_req_t;

    typedef struct packed {
        logic [ID_BITS-1:0]   head_id;
        logic [PRIO_BITS-1:0] head_priority;
        logic [1:0]           status;
        logic                 now_empty;
    } rdyq_rsp_t;

    // One stored queue entry
    typedef struct packed {
        logic                 valid;
        logic [ID_BITS-1:0]   id;
        logic [PRIO_BITS-1:0] prio;
    } rdyq_entry_t;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic enq_go;
        logic deq_go;
        logic prio_mode;
    } rdyq_ctl_t;

endpackage

// File: hdl/ready_queue_fifo_or_priority_top.sv
// Top level: ready queue built as a chain of entry cells, head at cell 0.
// Result: registered as its request transaction is accepted, presented in the next cycle.
// Throughput: one request per cycle while no result is stalled; insertion point is found by a
// ripple through all DEPTH cells in the same cycle, which sets the critical path.
// Reset: queue empty (all cell valid bits cleared), FIFO mode, no result pending.
module ready_queue_fifo_or_priority_top #(
    parameter int DEPTH = rdyq_pkg::DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  rdyq_pkg::rdyq_req_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rdyq_pkg::rdyq_rsp_t rsp,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               queue_mode
);
    import rdyq_pkg::*;

    logic        queue_mode_reg;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    rdyq_rsp_t   rsp_reg;
    rdyq_rsp_t   rsp_next;
    rdyq_ctl_t   ctl;
    rdyq_entry_t new_entry;
    rdyq_entry_t empty_entry;
    rdyq_entry_t cells [DEPTH];
    logic [DEPTH:0] found;
    logic        req_go;
    logic        is_full;
    logic        is_empty;

    assign cfg_ready = 1'b1;
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign req_go    = req_valid && req_ready;
    assign is_full   = cells[DEPTH-1].valid;
    assign is_empty  = !cells[0].valid;

    assign new_entry.valid   = 1'b1;
    assign new_entry.id      = req.task_id;
    assign new_entry.prio    = req.task_priority;
    assign empty_entry.valid = 1'b0;
    assign empty_entry.id    = '0;
    assign empty_entry.prio  = '0;

    // Broadcast operation to the chain
    assign ctl.enq_go    = req_go && (req.func == FUNC_ENQUEUE) && !is_full;
    assign ctl.deq_go    = req_go && (req.func == FUNC_DEQUEUE) && !is_empty;
    assign ctl.prio_mode = queue_mode_reg;

    assign found[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            rdyq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .strict     ((g == 0) ? 1'b1 : 1'b0),
                .new_entry  (new_entry),
                .prev_entry ((g == 0) ? new_entry : cells[(g == 0) ? 0 : g-1]),
                .next_entry ((g == DEPTH-1) ? empty_entry
                                            : cells[(g == DEPTH-1) ? g : g+1]),
                .found_in   (found[g]),
                .found_out  (found[g+1]),
                .entry      (cells[g])
            );
        end
    endgenerate

    // Build the result of the accepted transaction
    always_comb
    begin
        rsp_next.head_id       = '0;
        rsp_next.head_priority = '0;
        rsp_next.status        = STATUS_OK;
        rsp_next.now_empty     = is_empty;
        unique case (req.func)
            FUNC_ENQUEUE:
            begin
                if (is_full)
                begin
                    rsp_next.status = STATUS_FULL;
                end
                rsp_next.now_empty = 1'b0;
            end
            FUNC_DEQUEUE, FUNC_PEEK:
            begin
                if (is_empty)
                begin
                    rsp_next.status = STATUS_EMPTY;
                end
                else
                begin
                    rsp_next.head_id       = cells[0].id;
                    rsp_next.head_priority = cells[0].prio;
                    if (req.func == FUNC_DEQUEUE)
                    begin
                        rsp_next.now_empty = !cells[1].valid;
                    end
                end
            end
            default:
            begin
                rsp_next.now_empty = is_empty;
            end
        endcase
    end

    // Advance the output register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        priority if (req_go)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Hold mode register and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_mode_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                queue_mode_reg <= queue_mode;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Capture result payload
    always_ff @(posedge clk)
    begin
        if (req_go)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: hdl/rdyq_cell.sv
// Queue cell: holds one entry and shifts toward head or tail with its neighbors.
module rdyq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  rdyq_pkg::rdyq_ctl_t   ctl,
    input  logic                strict,
    input  rdyq_pkg::rdyq_entry_t new_entry,
    input  rdyq_pkg::rdyq_entry_t prev_entry,
    input  rdyq_pkg::rdyq_entry_t next_entry,
    input  logic                found_in,
    output logic                found_out,
    output rdyq_pkg::rdyq_entry_t entry
);
    import rdyq_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [ID_BITS-1:0]   id_reg;
    logic [ID_BITS-1:0]   id_next;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [PRIO_BITS-1:0] prio_next;
    logic                 prio_hit;
    logic                 stop;

    // Decide whether the new entry belongs at or before this cell
    assign prio_hit  = strict ? (new_entry.prio > prio_reg) : (new_entry.prio >= prio_reg);
    assign stop      = !valid_reg || (ctl.prio_mode && prio_hit);
    assign found_out = found_in || stop;

    // Select hold, load, shift toward tail, or shift toward head
    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        prio_next  = prio_reg;
        priority if (ctl.enq_go && found_in)
        begin
            valid_next = prev_entry.valid;
            id_next    = prev_entry.id;
            prio_next  = prev_entry.prio;
        end
        else if (ctl.enq_go && stop)
        begin
            valid_next = 1'b1;
            id_next    = new_entry.id;
            prio_next  = new_entry.prio;
        end
        else if (ctl.deq_go)
        begin
            valid_next = next_entry.valid;
            id_next    = next_entry.id;
            prio_next  = next_entry.prio;
        end
    end

    // Hold entry valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold entry payload
    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

    assign entry.valid = valid_reg;
    assign entry.id    = id_reg;
    assign entry.prio  = prio_reg;

endmodule
